FILE: design/rbwb_pkg.sv
// ----------------------------------------------------------------------------
// rbwb_pkg
// Shared types, register indexes and saturation helpers for the rotated box
// world bounds unit.
// ----------------------------------------------------------------------------
package rbwb_pkg;

	localparam int DW    = 32;
	localparam int HW    = 31;
	localparam int PC_W  = 48;
	localparam int PH_W  = 47;
	localparam int CTR_W = 50;
	localparam int EXT_W = 49;
	localparam int SUM_W = 51;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_HALF_X,
		REG_HALF_Y,
		REG_HALF_Z,
		REG_CTR_X,
		REG_CTR_Y,
		REG_CTR_Z
	} reg_idx_t;

	typedef struct packed {
		logic [8:0][DW-1:0] r;
		logic [8:0][DW-1:0] ar;
		logic [2:0][DW-1:0] t;
	} prep_t;

	typedef struct packed {
		logic [8:0][PC_W-1:0] pc;
		logic [8:0][PH_W-1:0] ph;
		logic [2:0][DW-1:0]   t;
	} prod_t;

	typedef struct packed {
		logic [2:0][CTR_W-1:0] ctr;
		logic [2:0][EXT_W-1:0] ext;
	} acc_t;

	typedef struct packed {
		logic [2:0][DW-1:0] wc;
		logic [2:0][DW-1:0] bmax;
		logic [2:0][DW-1:0] bmin;
		logic [2:0][HW-1:0] ext;
	} box_t;

	function automatic logic [DW-1:0] sat_s32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -SUM_W'(64'sd2147483648);
		if (v > hi) begin
			return 32'h7FFF_FFFF;
		end else if (v < lo) begin
			return 32'h8000_0000;
		end
		return v[DW-1:0];
	endfunction

	function automatic logic [HW-1:0] sat_u31(input logic [EXT_W-1:0] v);
		if (|v[EXT_W-1:HW]) begin
			return {HW{1'b1}};
		end
		return v[HW-1:0];
	endfunction

endpackage

FILE: design/rbwb_prep.sv
// ----------------------------------------------------------------------------
// rbwb_prep
// First pipeline stage: registers the matrix and translation and forms the
// magnitude of every matrix entry.
// ----------------------------------------------------------------------------
module rbwb_prep (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	input  logic [8:0][rbwb_pkg::DW-1:0] mat,
	input  logic [2:0][rbwb_pkg::DW-1:0] shift,
	output rbwb_pkg::prep_t            q
);

	rbwb_pkg::prep_t d;
	rbwb_pkg::prep_t data_s1;
	logic            valid_s1;

	always_comb begin
		d.r = mat;
		d.t = shift;
		for (int k = 0; k < 9; k++) begin
			d.ar[k] = mat[k][rbwb_pkg::DW-1] ? rbwb_pkg::DW'(-mat[k]) : mat[k];
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= d;
		end
	end

	assign dn_valid = valid_s1;
	assign q        = data_s1;

endmodule

FILE: design/rbwb_mul.sv
// ----------------------------------------------------------------------------
// rbwb_mul
// Second pipeline stage: the nine center products and the nine half width
// products, each truncated to sixteen fraction bits (Q32.16 center, unsigned
// Q31.16 half width) and registered.
module rbwb_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	input  rbwb_pkg::prep_t              d,
	input  logic [2:0][rbwb_pkg::DW-1:0] center,
	input  logic [2:0][rbwb_pkg::HW-1:0] half,
	output rbwb_pkg::prod_t              q
);

	logic signed [2*rbwb_pkg::DW-1:0]              pc_full [9];
	logic        [rbwb_pkg::DW+rbwb_pkg::HW-1:0]   ph_full [9];
	rbwb_pkg::prod_t                               nx;
	rbwb_pkg::prod_t                               data_s2;
	logic                                          valid_s2;

	always_comb begin
		nx.t = d.t;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pc_full[i*3+j] = $signed(d.r[i*3+j]) * $signed(center[j]);
				ph_full[i*3+j] = d.ar[i*3+j] * half[j];
				nx.pc[i*3+j]   = pc_full[i*3+j][2*rbwb_pkg::DW-1:16];
				nx.ph[i*3+j]   = ph_full[i*3+j][rbwb_pkg::DW+rbwb_pkg::HW-1:16];
			end
		end
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= nx;
		end
	end

	assign dn_valid = valid_s2;
	assign q        = data_s2;

endmodule

FILE: design/rbwb_acc.sv
// ----------------------------------------------------------------------------
// rbwb_acc
// Third pipeline stage: per axis, the world center before saturation and the
// extent of the aligned box.
// ----------------------------------------------------------------------------
module rbwb_acc (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	output logic            dn_valid,
	input  logic            dn_ready,
	input  rbwb_pkg::prod_t d,
	output rbwb_pkg::acc_t  q
);

	rbwb_pkg::acc_t nx;
	rbwb_pkg::acc_t data_s3;
	logic           valid_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nx.ctr[i] = rbwb_pkg::CTR_W'($signed(d.t[i]))
				+ rbwb_pkg::CTR_W'($signed(d.pc[i*3]))
				+ rbwb_pkg::CTR_W'($signed(d.pc[i*3+1]))
				+ rbwb_pkg::CTR_W'($signed(d.pc[i*3+2]));
			nx.ext[i] = rbwb_pkg::EXT_W'(d.ph[i*3])
				+ rbwb_pkg::EXT_W'(d.ph[i*3+1])
				+ rbwb_pkg::EXT_W'(d.ph[i*3+2]);
		end
	end

	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s3 <= nx;
		end
	end

	assign dn_valid = valid_s3;
	assign q        = data_s3;

endmodule

FILE: design/rbwb_sat.sv
// ----------------------------------------------------------------------------
// rbwb_sat
// Last pipeline stage and output register: forms the bounds from the center
// and extent and saturates every result field.
// ----------------------------------------------------------------------------
module rbwb_sat (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	output logic           dn_valid,
	input  logic           dn_ready,
	input  rbwb_pkg::acc_t d,
	output rbwb_pkg::box_t q
);

	logic signed [rbwb_pkg::SUM_W-1:0] ctr_w [3];
	logic signed [rbwb_pkg::SUM_W-1:0] ext_w [3];
	rbwb_pkg::box_t                    nx;
	rbwb_pkg::box_t                    data_s4;
	logic                              valid_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ctr_w[i]   = rbwb_pkg::SUM_W'($signed(d.ctr[i]));
			ext_w[i]   = $signed({2'b00, d.ext[i]});
			nx.wc[i]   = rbwb_pkg::sat_s32(ctr_w[i]);
			nx.bmax[i] = rbwb_pkg::sat_s32(ctr_w[i] + ext_w[i]);
			nx.bmin[i] = rbwb_pkg::sat_s32(ctr_w[i] - ext_w[i]);
			nx.ext[i]  = rbwb_pkg::sat_u31(d.ext[i]);
		end
	end

	assign up_ready = !valid_s4 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (up_ready) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s4 <= nx;
		end
	end

	assign dn_valid = valid_s4;
	assign q        = data_s4;

endmodule

FILE: design/rotated_box_world_bounds_unit.sv
// ----------------------------------------------------------------------------
// rotated_box_world_bounds_unit
// Transforms a configured local box by a model matrix and returns the world
// center and the axis-aligned bounds of the rotated box.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Contents
// mat       in         mat_valid/mat_stall   matrix r0c0..r2c2, shift x/y/z
// box       out        box_valid/box_stall   center, max, min, extent x/y/z
// cfg       in         cfg_wen               cfg_idx, cfg_wdata
//
// One transaction is accepted per cycle while mat_stall is low; its result
// passes through one register in each of the abs, multiply, sum and saturate
// stages before it is valid at the output. Each stage holds its own valid bit
// and takes new data whenever it is empty or its successor moves, so bubbles
// are squeezed out under stall.
// Reset clears the stage valid bits and all configuration registers.
// ----------------------------------------------------------------------------
module rotated_box_world_bounds_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [rbwb_pkg::IDX_W-1:0]        cfg_idx,
	input  logic [rbwb_pkg::DW-1:0]           cfg_wdata,
	input  logic                              mat_valid,
	output logic                              mat_stall,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r0c0,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r0c1,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r0c2,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r1c0,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r1c1,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r1c2,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r2c0,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r2c1,
	input  logic signed [rbwb_pkg::DW-1:0]    mat_r2c2,
	input  logic signed [rbwb_pkg::DW-1:0]    shift_x,
	input  logic signed [rbwb_pkg::DW-1:0]    shift_y,
	input  logic signed [rbwb_pkg::DW-1:0]    shift_z,
	output logic                              box_valid,
	input  logic                              box_stall,
	output logic signed [rbwb_pkg::DW-1:0]    world_center_x,
	output logic signed [rbwb_pkg::DW-1:0]    world_center_y,
	output logic signed [rbwb_pkg::DW-1:0]    world_center_z,
	output logic signed [rbwb_pkg::DW-1:0]    bound_max_x,
	output logic signed [rbwb_pkg::DW-1:0]    bound_max_y,
	output logic signed [rbwb_pkg::DW-1:0]    bound_max_z,
	output logic signed [rbwb_pkg::DW-1:0]    bound_min_x,
	output logic signed [rbwb_pkg::DW-1:0]    bound_min_y,
	output logic signed [rbwb_pkg::DW-1:0]    bound_min_z,
	output logic        [rbwb_pkg::HW-1:0]    extent_x,
	output logic        [rbwb_pkg::HW-1:0]    extent_y,
	output logic        [rbwb_pkg::HW-1:0]    extent_z
);

	logic [2:0][rbwb_pkg::HW-1:0] half_q;
	logic [2:0][rbwb_pkg::DW-1:0] center_q;
	logic [8:0][rbwb_pkg::DW-1:0] mat;
	logic [2:0][rbwb_pkg::DW-1:0] shift;

	rbwb_pkg::prep_t prep_q;
	rbwb_pkg::prod_t prod_q;
	rbwb_pkg::acc_t  acc_q;
	rbwb_pkg::box_t  box_q;

	logic ready1, ready2, ready3, ready4;
	logic valid1, valid2, valid3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= '0;
			center_q <= '0;
		end else if (cfg_wen) begin
			case (rbwb_pkg::reg_idx_t'(cfg_idx))
				rbwb_pkg::REG_HALF_X: half_q[0]   <= cfg_wdata[rbwb_pkg::HW-1:0];
				rbwb_pkg::REG_HALF_Y: half_q[1]   <= cfg_wdata[rbwb_pkg::HW-1:0];
				rbwb_pkg::REG_HALF_Z: half_q[2]   <= cfg_wdata[rbwb_pkg::HW-1:0];
				rbwb_pkg::REG_CTR_X:  center_q[0] <= cfg_wdata;
				rbwb_pkg::REG_CTR_Y:  center_q[1] <= cfg_wdata;
				rbwb_pkg::REG_CTR_Z:  center_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign mat   = {mat_r2c2, mat_r2c1, mat_r2c0, mat_r1c2, mat_r1c1, mat_r1c0,
		mat_r0c2, mat_r0c1, mat_r0c0};
	assign shift = {shift_z, shift_y, shift_x};

	rbwb_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mat_valid),
		.up_ready (ready1),
		.dn_valid (valid1),
		.dn_ready (ready2),
		.mat      (mat),
		.shift    (shift),
		.q        (prep_q)
	);

	rbwb_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid1),
		.up_ready (ready2),
		.dn_valid (valid2),
		.dn_ready (ready3),
		.d        (prep_q),
		.center   (center_q),
		.half     (half_q),
		.q        (prod_q)
	);

	rbwb_acc u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid2),
		.up_ready (ready3),
		.dn_valid (valid3),
		.dn_ready (ready4),
		.d        (prod_q),
		.q        (acc_q)
	);

	rbwb_sat u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid3),
		.up_ready (ready4),
		.dn_valid (box_valid),
		.dn_ready (!box_stall),
		.d        (acc_q),
		.q        (box_q)
	);

	assign mat_stall = !ready1;

	assign world_center_x = box_q.wc[0];
	assign world_center_y = box_q.wc[1];
	assign world_center_z = box_q.wc[2];
	assign bound_max_x    = box_q.bmax[0];
	assign bound_max_y    = box_q.bmax[1];
	assign bound_max_z    = box_q.bmax[2];
	assign bound_min_x    = box_q.bmin[0];
	assign bound_min_y    = box_q.bmin[1];
	assign bound_min_z    = box_q.bmin[2];
	assign extent_x       = box_q.ext[0];
	assign extent_y       = box_q.ext[1];
	assign extent_z       = box_q.ext[2];

	// An empty output register must leave the whole pipeline open.
	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!box_valid |-> !mat_stall)
		else $error("input stalled while output register is empty");

	// An accepted transaction always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_stall |=> valid1)
		else $error("accepted transaction lost at first stage");

	// The center lies inside the bounds on every axis.
	a_order_x: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (bound_min_x <= world_center_x) && (world_center_x <= bound_max_x))
		else $error("x bounds out of order");

	a_order_y: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (bound_min_y <= world_center_y) && (world_center_y <= bound_max_y))
		else $error("y bounds out of order");

	a_order_z: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (bound_min_z <= world_center_z) && (world_center_z <= bound_max_z))
		else $error("z bounds out of order");

endmodule

FILE: tb/box_bounds_checker.sv
// ----------------------------------------------------------------------------
// box_bounds_checker
// Watches the configuration port and both channels of the rotated box world
// bounds unit. It keeps its own copy of the box registers, computes the
// world center, bounds and extents of every accepted matrix transaction, and
// compares each accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module box_bounds_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [rbwb_pkg::IDX_W-1:0] cfg_idx,
	input  logic [rbwb_pkg::DW-1:0]    cfg_wdata,
	input  logic                       mat_valid,
	input  logic                       mat_stall,
	input  logic [rbwb_pkg::DW-1:0]    mat_r0c0,
	input  logic [rbwb_pkg::DW-1:0]    mat_r0c1,
	input  logic [rbwb_pkg::DW-1:0]    mat_r0c2,
	input  logic [rbwb_pkg::DW-1:0]    mat_r1c0,
	input  logic [rbwb_pkg::DW-1:0]    mat_r1c1,
	input  logic [rbwb_pkg::DW-1:0]    mat_r1c2,
	input  logic [rbwb_pkg::DW-1:0]    mat_r2c0,
	input  logic [rbwb_pkg::DW-1:0]    mat_r2c1,
	input  logic [rbwb_pkg::DW-1:0]    mat_r2c2,
	input  logic [rbwb_pkg::DW-1:0]    shift_x,
	input  logic [rbwb_pkg::DW-1:0]    shift_y,
	input  logic [rbwb_pkg::DW-1:0]    shift_z,
	input  logic                       box_valid,
	input  logic                       box_stall,
	input  logic [rbwb_pkg::DW-1:0]    world_center_x,
	input  logic [rbwb_pkg::DW-1:0]    world_center_y,
	input  logic [rbwb_pkg::DW-1:0]    world_center_z,
	input  logic [rbwb_pkg::DW-1:0]    bound_max_x,
	input  logic [rbwb_pkg::DW-1:0]    bound_max_y,
	input  logic [rbwb_pkg::DW-1:0]    bound_max_z,
	input  logic [rbwb_pkg::DW-1:0]    bound_min_x,
	input  logic [rbwb_pkg::DW-1:0]    bound_min_y,
	input  logic [rbwb_pkg::DW-1:0]    bound_min_z,
	input  logic [rbwb_pkg::HW-1:0]    extent_x,
	input  logic [rbwb_pkg::HW-1:0]    extent_y,
	input  logic [rbwb_pkg::HW-1:0]    extent_z,
	output int                         failures,
	output int                         pending
);
	import rbwb_pkg::*;

	localparam longint S32_TOP    = 64'sd2147483647;
	localparam longint S32_BOTTOM = -64'sd2147483648;

	typedef logic [11:0][DW-1:0] box_word_t;

	longint    half_q [3];
	longint    centre_q [3];
	box_word_t expected_boxes [$];
	box_word_t box_word;
	box_word_t oldest_box;
	logic [8:0][DW-1:0] mat_word;
	logic [2:0][DW-1:0] shift_word;

	string field_name [12] = '{
		"world_center_x", "world_center_y", "world_center_z",
		"bound_max_x", "bound_max_y", "bound_max_z",
		"bound_min_x", "bound_min_y", "bound_min_z",
		"extent_x", "extent_y", "extent_z"
	};

	assign mat_word = {mat_r2c2, mat_r2c1, mat_r2c0, mat_r1c2, mat_r1c1, mat_r1c0,
		mat_r0c2, mat_r0c1, mat_r0c0};
	assign shift_word = {shift_z, shift_y, shift_x};
	assign box_word = {{1'b0, extent_z}, {1'b0, extent_y}, {1'b0, extent_x},
		bound_min_z, bound_min_y, bound_min_x,
		bound_max_z, bound_max_y, bound_max_x,
		world_center_z, world_center_y, world_center_x};

	function automatic longint as_signed(input logic [DW-1:0] v);
		logic signed [DW-1:0] s;
		s = v;
		return s;
	endfunction

	function automatic logic [DW-1:0] clamp_s32(input longint v);
		if (v > S32_TOP) begin
			return 32'h7FFF_FFFF;
		end
		if (v < S32_BOTTOM) begin
			return 32'h8000_0000;
		end
		return v[DW-1:0];
	endfunction

	function automatic logic [HW-1:0] clamp_u31(input longint v);
		if (v < 0) begin
			return '0;
		end
		if (v > S32_TOP) begin
			return '1;
		end
		return v[HW-1:0];
	endfunction

	function automatic box_word_t predict_box(input logic [8:0][DW-1:0] mat,
			input logic [2:0][DW-1:0] shift);
		box_word_t res;
		longint    ctr;
		longint    ext;
		longint    r;
		longint    ar;
		int        i;
		int        j;
		for (i = 0; i < 3; i++) begin
			ctr = as_signed(shift[i]);
			ext = 0;
			for (j = 0; j < 3; j++) begin
				r = as_signed(mat[i * 3 + j]);
				ar = (r < 0) ? -r : r;
				ctr += (r * centre_q[j]) >>> 16;
				ext += (ar * half_q[j]) >>> 16;
			end
			res[i] = clamp_s32(ctr);
			res[3 + i] = clamp_s32(ctr + ext);
			res[6 + i] = clamp_s32(ctr - ext);
			res[9 + i] = {1'b0, clamp_u31(ext)};
		end
		return res;
	endfunction

	initial begin
		failures = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				half_q[k] = 0;
				centre_q[k] = 0;
			end
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_HALF_X: half_q[0] = cfg_wdata[HW-1:0];
					REG_HALF_Y: half_q[1] = cfg_wdata[HW-1:0];
					REG_HALF_Z: half_q[2] = cfg_wdata[HW-1:0];
					REG_CTR_X: centre_q[0] = as_signed(cfg_wdata);
					REG_CTR_Y: centre_q[1] = as_signed(cfg_wdata);
					REG_CTR_Z: centre_q[2] = as_signed(cfg_wdata);
					default: begin
					end
				endcase
			end
			if (box_valid && !box_stall) begin
				if (expected_boxes.size() == 0) begin
					$display("%0t: box transaction with none outstanding, expected none actual %h",
						$time, box_word);
					failures++;
				end else begin
					oldest_box = expected_boxes.pop_front();
					for (int k = 0; k < 12; k++) begin
						if (box_word[k] !== oldest_box[k]) begin
							$display("%0t: %s expected %h actual %h", $time, field_name[k],
								oldest_box[k], box_word[k]);
							failures++;
						end
					end
				end
			end
			if (mat_valid && !mat_stall) begin
				expected_boxes.push_back(predict_box(mat_word, shift_word));
			end
			pending <= expected_boxes.size();
		end
	end

endmodule

FILE: tb/rotated_box_world_bounds_unit_tb.sv
// ----------------------------------------------------------------------------
// rotated_box_world_bounds_unit_tb
// Drives matrix transactions into the rotated box world bounds unit under
// random sender gaps and receiver stalls. A directed set covers identity,
// rotation, full-scale and most-negative entries and saturating bounds; then
// random phases each reprogram the box registers while the unit is idle.
// A checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module rotated_box_world_bounds_unit_tb;
	import rbwb_pkg::*;

	localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam logic [DW-1:0]    Q_ONE        = 32'h0001_0000;
	localparam logic [DW-1:0]    Q_NEG_ONE    = 32'hFFFF_0000;
	localparam logic [DW-1:0]    Q_MAX        = 32'h7FFF_FFFF;
	localparam logic [DW-1:0]    Q_MIN        = 32'h8000_0000;
	localparam int               PHASES       = 5;
	localparam int               PHASE_ITEMS  = 250;
	localparam int               QUIET_ITEMS  = 100;

	typedef enum int {
		STYLE_FULL,
		STYLE_SMALL,
		STYLE_EDGE
	} value_style_t;

	typedef struct packed {
		logic [8:0][DW-1:0] m;
		logic [2:0][DW-1:0] s;
	} mat_item_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [IDX_W-1:0] cfg_idx;
	logic [DW-1:0]    cfg_wdata;
	logic             mat_valid;
	logic             mat_stall;
	logic [DW-1:0]    mat_r0c0;
	logic [DW-1:0]    mat_r0c1;
	logic [DW-1:0]    mat_r0c2;
	logic [DW-1:0]    mat_r1c0;
	logic [DW-1:0]    mat_r1c1;
	logic [DW-1:0]    mat_r1c2;
	logic [DW-1:0]    mat_r2c0;
	logic [DW-1:0]    mat_r2c1;
	logic [DW-1:0]    mat_r2c2;
	logic [DW-1:0]    shift_x;
	logic [DW-1:0]    shift_y;
	logic [DW-1:0]    shift_z;
	logic             box_valid;
	logic             box_stall;
	logic [DW-1:0]    world_center_x;
	logic [DW-1:0]    world_center_y;
	logic [DW-1:0]    world_center_z;
	logic [DW-1:0]    bound_max_x;
	logic [DW-1:0]    bound_max_y;
	logic [DW-1:0]    bound_max_z;
	logic [DW-1:0]    bound_min_x;
	logic [DW-1:0]    bound_min_y;
	logic [DW-1:0]    bound_min_z;
	logic [HW-1:0]    extent_x;
	logic [HW-1:0]    extent_y;
	logic [HW-1:0]    extent_z;
	int               failures;
	int               pending;
	bit               quiet_tail;

	rotated_box_world_bounds_unit dut (.*);

	box_bounds_checker u_bounds_check (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [DW-1:0] rand_value(input value_style_t style);
		case (style)
			STYLE_FULL: begin
				return $urandom();
			end
			STYLE_SMALL: begin
				return DW'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return Q_ONE;
					2: return Q_NEG_ONE;
					3: return Q_MAX;
					default: return Q_MIN;
				endcase
			end
		endcase
	endfunction

	function automatic value_style_t pick_style();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return STYLE_FULL;
			4, 5, 6, 7: return STYLE_SMALL;
			default: return STYLE_EDGE;
		endcase
	endfunction

	function automatic mat_item_t rand_item();
		mat_item_t    it;
		value_style_t m_style;
		value_style_t s_style;
		bit           mixed;
		m_style = pick_style();
		s_style = pick_style();
		mixed = ($urandom_range(0, 4) == 0);
		for (int k = 0; k < 9; k++) begin
			it.m[k] = rand_value(mixed ? pick_style() : m_style);
		end
		for (int k = 0; k < 3; k++) begin
			it.s[k] = rand_value(s_style);
		end
		return it;
	endfunction

	function automatic mat_item_t fill_item(input logic [DW-1:0] e, input logic [DW-1:0] s);
		mat_item_t it;
		it.m = {9{e}};
		it.s = {3{s}};
		return it;
	endfunction

	function automatic mat_item_t diag_item(input logic [DW-1:0] d, input logic [DW-1:0] s);
		mat_item_t it;
		it = fill_item('0, s);
		it.m[0] = d;
		it.m[4] = d;
		it.m[8] = d;
		return it;
	endfunction

	task automatic push_matrix(input mat_item_t it);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			mat_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		mat_valid <= 1'b1;
		mat_r0c0 <= it.m[0];
		mat_r0c1 <= it.m[1];
		mat_r0c2 <= it.m[2];
		mat_r1c0 <= it.m[3];
		mat_r1c1 <= it.m[4];
		mat_r1c2 <= it.m[5];
		mat_r2c0 <= it.m[6];
		mat_r2c1 <= it.m[7];
		mat_r2c2 <= it.m[8];
		shift_x <= it.s[0];
		shift_y <= it.s[1];
		shift_z <= it.s[2];
		@(posedge clk);
		while (mat_stall) @(posedge clk);
	endtask

	task automatic settle();
		mat_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
	endtask

	task automatic program_box(input logic [DW-1:0] hx, input logic [DW-1:0] hy,
			input logic [DW-1:0] hz, input logic [DW-1:0] cx, input logic [DW-1:0] cy,
			input logic [DW-1:0] cz);
		write_reg(IDX_SPARE_LO, $urandom());
		write_reg(REG_HALF_X, hx);
		write_reg(REG_HALF_Y, hy);
		write_reg(REG_HALF_Z, hz);
		write_reg(REG_CTR_X, cx);
		write_reg(REG_CTR_Y, cy);
		write_reg(REG_CTR_Z, cz);
		write_reg(IDX_SPARE_HI, $urandom());
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [DW-1:0] rand_half(input value_style_t style);
		if (style == STYLE_SMALL) begin
			return $urandom_range(0, 32'h0003_0000);
		end
		return rand_value(style);
	endfunction

	initial begin
		box_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				box_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				box_stall <= 1'b0;
			end
		end
	end

	initial begin
		mat_item_t    rot;
		value_style_t cfg_style [PHASES];
		cfg_style = '{STYLE_SMALL, STYLE_FULL, STYLE_EDGE, STYLE_FULL, STYLE_SMALL};
		rot = diag_item('0, '0);
		rot.m[1] = Q_NEG_ONE;
		rot.m[3] = Q_ONE;
		rot.m[8] = Q_ONE;
		quiet_tail = 1'b0;
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		mat_valid <= 1'b0;
		mat_r0c0 <= '0;
		mat_r0c1 <= '0;
		mat_r0c2 <= '0;
		mat_r1c0 <= '0;
		mat_r1c1 <= '0;
		mat_r1c2 <= '0;
		mat_r2c0 <= '0;
		mat_r2c1 <= '0;
		mat_r2c2 <= '0;
		shift_x <= '0;
		shift_y <= '0;
		shift_z <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_matrix(diag_item(Q_ONE, Q_ONE));
		push_matrix(fill_item(Q_MAX, Q_MAX));
		push_matrix(fill_item(Q_MIN, Q_MIN));
		settle();

		// Half widths written as all ones are stored as their low 31 bits, the 31-bit maximum.
		program_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_MAX);
		push_matrix(diag_item(Q_ONE, '0));
		push_matrix(fill_item(Q_MIN, '0));
		push_matrix(fill_item(Q_MAX, Q_MAX));
		push_matrix(fill_item('0, Q_MIN));
		push_matrix(rot);
		push_matrix(rot);
		push_matrix(diag_item(Q_NEG_ONE, Q_MAX));
		settle();

		program_box(Q_ONE, 32'h0002_0000, 32'h0000_8000, Q_MIN, '0, Q_MAX);
		push_matrix(diag_item(Q_ONE, '0));
		push_matrix(rot);
		push_matrix(diag_item(32'hFFFE_0000, Q_ONE));
		push_matrix(fill_item(Q_MIN, '0));
		push_matrix(fill_item(Q_MAX, '0));
		push_matrix(diag_item(Q_ONE, Q_MAX));
		push_matrix(diag_item(Q_ONE, Q_MIN));
		settle();

		// A center of minus one LSB checks that negative products round toward minus infinity.
		program_box('0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_matrix(fill_item(32'h0000_0001, '0));
		push_matrix(fill_item(32'hFFFF_FFFF, '0));
		push_matrix(fill_item(32'h0000_8000, Q_MIN));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			program_box(rand_half(cfg_style[p]), rand_half(cfg_style[p]),
				rand_half(cfg_style[p]), rand_value(cfg_style[p]),
				rand_value(cfg_style[p]), rand_value(cfg_style[p]));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == PHASES - 1 && n >= PHASE_ITEMS - QUIET_ITEMS) begin
					quiet_tail = 1'b1;
				end
				push_matrix(rand_item());
			end
			settle();
		end

		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
